// ===== hdl/hptt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hptt_pkg;
  localparam int SetCount = 256;
  localparam int WayCount = 4;
  localparam int PageShift = 12;
  localparam int SetBits = (SetCount > 1) ? $clog2(SetCount) : 1;
  localparam int WayBits = (WayCount > 1) ? $clog2(WayCount) : 1;
  localparam int SlotCount = SetCount * WayCount;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_MARK = 2'd1;
  localparam logic [1:0] OP_STATS = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_ENABLE = 1'b1;

  localparam logic [10:0] MAX11 = 11'h7ff;
  localparam logic [47:0] MAX48 = 48'hffff_ffff_ffff;
  localparam logic [31:0] MAX32 = 32'hffff_ffff;

  // one way of a set as stored in memory
  typedef struct packed {
    logic valid;
    logic [47:0] addr;
    logic [31:0] touches;
    logic attempted;
    logic migrated;
    logic [31:0] first_site;
  } way_t;
  localparam int WayWidth = $bits(way_t);

  typedef struct packed {
    logic [1:0] op;
    logic [47:0] page_addr;
    logic [31:0] site_id;
  } req_t;

  typedef struct packed {
    logic migrate_now;
    logic table_full;
    logic found;
    logic [31:0] entry_touches;
    logic [31:0] first_site;
    logic [10:0] page_total;
    logic [47:0] touch_total;
    logic [10:0] attempt_total;
    logic [10:0] success_total;
    logic [31:0] touch_peak;
  } rsp_t;

  function automatic logic [SetBits-1:0] set_of(input logic [47:0] a);
    logic [47:0] pg;
    pg = a >> PageShift;
    return pg[SetBits-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/hptt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hptt_req_if;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic [47:0] page_addr;
  logic [31:0] site_id;
  modport source(output valid, op, page_addr, site_id, input ready);
  modport sink(input valid, op, page_addr, site_id, output ready);
endinterface

interface hptt_rsp_if;
  logic valid;
  logic ready;
  logic migrate_now;
  logic table_full;
  logic found;
  logic [31:0] entry_touches;
  logic [31:0] first_site;
  logic [10:0] page_total;
  logic [47:0] touch_total;
  logic [10:0] attempt_total;
  logic [10:0] success_total;
  logic [31:0] touch_peak;
  modport source(output valid, migrate_now, table_full, found, entry_touches, first_site,
                 page_total, touch_total, attempt_total, success_total, touch_peak,
                 input ready);
  modport sink(input valid, migrate_now, table_full, found, entry_touches, first_site,
               page_total, touch_total, attempt_total, success_total, touch_peak,
               output ready);
endinterface

interface hptt_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/hptt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hptt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/hptt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// accept beats into a two-entry queue
module hptt_front (
  input wire logic clk,
  input wire logic rst,
  hptt_req_if.sink req,
  output hptt_pkg::req_t head,
  output logic head_valid,
  input wire logic head_pop
);
  hptt_pkg::req_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push;

  assign req.ready = (count != 2'd2);
  assign push = req.valid && req.ready;
  assign head = q[rd_ptr];
  assign head_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= '{req.op, req.page_addr, req.site_id};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (head_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(head_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid) else $error("pop on empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !head_pop) |=> count == 2'd2) else $error("queue lost a beat");
`endif
endmodule
`default_nettype wire

// ===== hdl/hptt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// set read-modify-write engine: read cycle, then update/respond cycle
module hptt_back (
  input wire logic clk,
  input wire logic rst,
  input hptt_pkg::req_t head,
  input wire logic head_valid,
  output logic head_pop,
  input wire logic [31:0] threshold,
  input wire logic enable,
  hptt_rsp_if.source rsp
);
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  localparam int W = hptt_pkg::WayCount;
  localparam int SB = hptt_pkg::SetBits;
  localparam int SetDepth = (hptt_pkg::SetCount > 1) ? hptt_pkg::SetCount : 2;
  localparam int AB = $clog2(SetDepth);

  state_t state;
  hptt_pkg::req_t cur;
  logic [hptt_pkg::WayWidth-1:0] rdata [W];
  logic [W-1:0] we;
  hptt_pkg::way_t wway;
  logic [AB-1:0] raddr, waddr, clr_addr;
  logic [SB-1:0] cur_set;

  logic [10:0] pages_held, attempts_counted, successes_counted;
  logic [47:0] touches_summed;
  logic [31:0] peak_touches;
  logic rsp_busy;

  assign cur_set = hptt_pkg::set_of(cur.page_addr);
  // keep reading the current set while a beat waits so the read data holds
  assign raddr = head_pop ? AB'(hptt_pkg::set_of(head.page_addr)) : AB'(cur_set);
  assign waddr = (state == ST_CLEAR) ? clr_addr : AB'(cur_set);

  genvar g;
  generate
    for (g = 0; g < W; g++) begin : g_way
      hptt_ram #(.Width(hptt_pkg::WayWidth), .Depth(SetDepth)) u_ram (
        .clk(clk), .we(we[g]), .waddr(waddr), .wdata(wway),
        .raddr(raddr), .rdata(rdata[g])
      );
    end
  endgenerate

  // pop whenever idle and a beat waits; exec then stalls until the output slot is free
  assign head_pop = (state == ST_IDLE) && head_valid;

  // hit and free-way search over the set
  logic [W-1:0] vset, hit;
  logic hit_any, free_any;
  logic [hptt_pkg::WayBits-1:0] hit_way, free_way, sel_way;
  hptt_pkg::way_t ways [W];
  always_comb begin
    hit_any = 1'b0;
    free_any = 1'b0;
    hit_way = '0;
    free_way = '0;
    for (int i = 0; i < W; i++) begin
      ways[i] = hptt_pkg::way_t'(rdata[i]);
      vset[i] = ways[i].valid;
      hit[i] = vset[i] && (ways[i].addr == cur.page_addr);
    end
    for (int i = W - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_way = hptt_pkg::WayBits'(i);
      end
      if (!vset[i]) begin
        free_any = 1'b1;
        free_way = hptt_pkg::WayBits'(i);
      end
    end
    sel_way = hit_any ? hit_way : free_way;
  end

  hptt_pkg::way_t old_way;
  hptt_pkg::rsp_t r;
  logic [10:0] pages_next, attempts_next, successes_next;
  logic [47:0] touches_next;
  logic [31:0] peak_next;
  always_comb begin
    old_way = ways[sel_way];
    if (!hit_any) old_way = '{1'b1, cur.page_addr, 32'd0, 1'b0, 1'b0, 32'd0};
    wway = old_way;
    we = '0;
    pages_next = pages_held;
    attempts_next = attempts_counted;
    successes_next = successes_counted;
    touches_next = touches_summed;
    peak_next = peak_touches;
    r = '0;
    if (cur.page_addr != 48'd0 && cur.op == hptt_pkg::OP_SAMPLE) begin
      if (!hit_any && !free_any) begin
        r.table_full = 1'b1;
      end else begin
        if (!hit_any) begin
          if (pages_held != hptt_pkg::MAX11) pages_next = pages_held + 11'd1;
        end
        if (wway.first_site == 32'd0) wway.first_site = cur.site_id;
        if (wway.touches != hptt_pkg::MAX32) begin
          wway.touches = wway.touches + 32'd1;
          if (touches_summed != hptt_pkg::MAX48) touches_next = touches_summed + 48'd1;
        end
        if (wway.touches > peak_touches) peak_next = wway.touches;
        if (enable && !wway.attempted && wway.touches >= threshold) begin
          wway.attempted = 1'b1;
          if (attempts_counted != hptt_pkg::MAX11) attempts_next = attempts_counted + 11'd1;
          r.migrate_now = 1'b1;
        end
        we[sel_way] = 1'b1;
        r.found = 1'b1;
        r.entry_touches = wway.touches;
        r.first_site = wway.first_site;
      end
    end else if (cur.page_addr != 48'd0 && cur.op == hptt_pkg::OP_MARK && hit_any) begin
      if (!wway.migrated) begin
        wway.migrated = 1'b1;
        if (successes_counted != hptt_pkg::MAX11)
          successes_next = successes_counted + 11'd1;
      end
      we[sel_way] = 1'b1;
      r.found = 1'b1;
      r.entry_touches = wway.touches;
      r.first_site = wway.first_site;
    end
    r.page_total = pages_next;
    r.touch_total = touches_next;
    r.attempt_total = attempts_next;
    r.success_total = successes_next;
    r.touch_peak = peak_next;
    // clearing pass writes empty ways to every set after reset
    if (state == ST_CLEAR) begin
      we = '1;
      wway = '0;
    end else if (state != ST_EXEC || rsp_busy) begin
      we = '0;
    end
  end

  logic exec_go;
  assign exec_go = (state == ST_EXEC) && !rsp_busy;

  always_ff @(posedge clk) begin
    if (head_pop) cur <= head;
    if (exec_go) begin
      {rsp.migrate_now, rsp.table_full, rsp.found, rsp.entry_touches, rsp.first_site,
       rsp.page_total, rsp.touch_total, rsp.attempt_total, rsp.success_total,
       rsp.touch_peak} <= r;
    end
  end

  assign rsp_busy = rsp.valid && !rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      rsp.valid <= 1'b0;
      pages_held <= '0;
      attempts_counted <= '0;
      successes_counted <= '0;
      touches_summed <= '0;
      peak_touches <= '0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AB'(1);
          if (clr_addr == AB'(SetDepth - 1)) state <= ST_IDLE;
        end
        ST_IDLE: if (head_pop) state <= ST_EXEC;
        ST_EXEC: begin
          if (!rsp_busy) begin
            state <= ST_IDLE;
            rsp.valid <= 1'b1;
            pages_held <= pages_next;
            attempts_counted <= attempts_next;
            successes_counted <= successes_next;
            touches_summed <= touches_next;
            peak_touches <= peak_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    state != ST_CLEAR |-> $onehot0(we)) else $error("more than one way written");
  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |-> $onehot0(hit)) else $error("page held in two ways");
  a_exec_resp: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> rsp.valid) else $error("exec produced no beat");
`endif
endmodule
`default_nettype wire

// ===== hdl/hot_page_touch_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// hot page touch tracker: a 256-set, 4-way table of page entries counting sampled
// lock-site touches. each request beat gives exactly one response beat. in the back
// end a beat's set is first read from synchronous memory, then that set is updated
// and written back; the back end takes no new beat until that write-back is done, and
// a two-entry queue in front takes beats while the back end works or the
// response register waits. valid bits are stored with each way in memory; after
// reset the back end runs a clearing pass over all 256 sets (one set per cycle)
// before it takes its first beat, and the front queue holds up to two beats
// meanwhile. config writes are taken at any time (always ready).
module hot_page_touch_tracker (
  input wire logic clk,
  input wire logic rst,
  hptt_cfg_if.sink cfg,
  hptt_req_if.sink req,
  hptt_rsp_if.source rsp
);
  hptt_pkg::req_t head;
  logic head_valid, head_pop;
  logic [31:0] threshold;
  logic enable;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 32'd64;
      enable <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        hptt_pkg::CFG_THRESHOLD: threshold <= cfg.data;
        hptt_pkg::CFG_ENABLE: enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  hptt_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .head(head), .head_valid(head_valid), .head_pop(head_pop)
  );

  hptt_back u_back (
    .clk(clk), .rst(rst), .head(head), .head_valid(head_valid), .head_pop(head_pop),
    .threshold(threshold), .enable(enable), .rsp(rsp)
  );
endmodule
`default_nettype wire
